FILE: rtl/core/tij_pkg.sv
// Shared constants for the tetrahedron inverse Jacobian: cofactor index tables.
`timescale 1ns / 1ps

package tij_pkg;

    // Axis codes for the coordinate table
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    localparam int NUM_AXES = 3;
    localparam int NUM_VERT = 4;
    localparam int NUM_COF  = 9;
    // Nine cofactors plus the one extra cyclic sum that the determinant needs
    localparam int NUM_CYC  = 10;
    localparam int NUM_TERM = 3;

    // Cyclic sum a_i(b_j-b_k) + a_j(b_k-b_i) + a_k(b_i-b_j): axes of a and b, vertices i, j, k
    localparam int CYC_A [NUM_CYC] = '{AXIS_Y, AXIS_X, AXIS_X, AXIS_Y, AXIS_X,
                                       AXIS_X, AXIS_Y, AXIS_X, AXIS_X, AXIS_Y};
    localparam int CYC_B [NUM_CYC] = '{AXIS_Z, AXIS_Z, AXIS_Y, AXIS_Z, AXIS_Z,
                                       AXIS_Y, AXIS_Z, AXIS_Z, AXIS_Y, AXIS_Z};
    localparam int CYC_I [NUM_CYC] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1};
    localparam int CYC_J [NUM_CYC] = '{2, 3, 2, 3, 1, 3, 1, 2, 1, 3};
    localparam int CYC_K [NUM_CYC] = '{3, 2, 3, 1, 3, 1, 2, 1, 2, 2};

    // Determinant expansion along x: vertex v multiplies cyclic sum DET_CYC[v]
    localparam int DET_CYC [NUM_VERT] = '{9, 0, 3, 6};

endpackage

FILE: rtl/core/tetra_inverse_jacobian.sv
// Top level: pipelined inverse Jacobian of a tetrahedron's affine map.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one word per tetrahedron, twelve signed fixed-point coordinates
//   vx0..vx3, vy0..vy3, vz0..vz3 packed from the lowest bit up.
//   m_ channel: one word per tetrahedron, the nine gradients dxi_dx .. dzeta_dz
//   in tdata and the degenerate / saturated flags in tuser.
//   Six stages build the differences, products, cofactors, determinant and
//   divider operands, then a restoring divider retires one quotient bit per
//   stage over COORD_WIDTH + 2 stages, and an output register applies sign
//   and saturation.
//   Throughput is one tetrahedron per cycle while the receiver does not stall;
//   all nine divisions run in parallel lanes sharing 2|D| as divisor.
//   A stalled receiver freezes the whole pipeline; a one-word skid register
//   on the input takes one more word meanwhile, so s_tready is registered.
//   Reset (aresetn low, synchronous) empties the pipeline and the skid stage.
//   A zero determinant returns zero gradients with degenerate set.
module tetra_inverse_jacobian #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // vx0, vx1, vx2, vx3, vy0, vy1, vy2, vy3, vz0, vz1, vz2, vz3
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // dxi_dx, dxi_dy, dxi_dz, deta_dx, deta_dy, deta_dz, dzeta_dx, dzeta_dy, dzeta_dz
    output logic [((9*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    // degenerate, saturated
    output logic [1:0]                                m_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;                 // coordinate difference
    localparam int PW     = 2 * W + 1;             // product a * difference
    localparam int CF     = 2 * W + 3;             // cofactor
    localparam int LOW    = W + 2;                 // low slice of a cofactor
    localparam int HIW    = CF - LOW;              // high slice of a cofactor
    localparam int PLW    = W + LOW + 1;           // x * low slice
    localparam int DETW   = 3 * W + 5;             // determinant
    localparam int MW     = DETW + 1;              // divisor 2|D|
    localparam int NW1    = CF + 2 * FRAC_BITS + 2;
    localparam int NW2    = (NW1 > DETW + 1) ? NW1 : DETW + 1;
    localparam int CW     = (NW2 > MW + W + 1) ? NW2 : MW + W + 1;
    localparam int QW     = W + 2;                 // quotient bits incl. overflow
    localparam int DIV_ST = W + 2;
    localparam int IN_BITS  = 12 * W;
    localparam int OUT_BITS = 9 * W;
    localparam int OUT_TW   = ((9 * W + 7) / 8) * 8;
    localparam int NCYC   = tij_pkg::NUM_CYC;
    localparam int NCOF   = tij_pkg::NUM_COF;
    localparam int NVERT  = tij_pkg::NUM_VERT;
    localparam int NTERM  = tij_pkg::NUM_TERM;

    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic advance;

    // Input skid stage
    logic               skid_valid_reg;
    logic [IN_BITS-1:0] skid_data_reg;
    logic               in_valid;
    logic [IN_BITS-1:0] in_data;

    // Hold the pipeline while a result waits at the output
    assign advance  = m_tready || !m_tvalid;
    assign s_tready = !skid_valid_reg;
    assign in_valid = skid_valid_reg || s_tvalid;
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata[IN_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (advance) begin
            skid_valid_reg <= 1'b0;
        end else if (s_tvalid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!advance && s_tvalid && !skid_valid_reg) begin
            skid_data_reg <= s_tdata[IN_BITS-1:0];
        end
    end

    // Unpack coordinates
    logic signed [W-1:0] crd [tij_pkg::NUM_AXES][NVERT];

    always_comb begin
        for (int a = 0; a < tij_pkg::NUM_AXES; a++) begin
            for (int v = 0; v < NVERT; v++) begin
                crd[a][v] = in_data[(a*NVERT+v)*W +: W];
            end
        end
    end

    // Stage 1: coordinate differences
    logic                 v1_reg;
    logic signed [W-1:0]  a1_next [NCYC][NTERM];
    logic signed [DW-1:0] d1_next [NCYC][NTERM];
    logic signed [W-1:0]  a1_reg  [NCYC][NTERM];
    logic signed [DW-1:0] d1_reg  [NCYC][NTERM];
    logic signed [W-1:0]  x1_reg  [NVERT];

    always_comb begin
        int ix [NTERM];
        for (int c = 0; c < NCYC; c++) begin
            ix[0] = tij_pkg::CYC_I[c];
            ix[1] = tij_pkg::CYC_J[c];
            ix[2] = tij_pkg::CYC_K[c];
            for (int t = 0; t < NTERM; t++) begin
                a1_next[c][t] = crd[tij_pkg::CYC_A[c]][ix[t]];
                d1_next[c][t] = DW'(crd[tij_pkg::CYC_B[c]][ix[(t+1)%NTERM]])
                              - DW'(crd[tij_pkg::CYC_B[c]][ix[(t+2)%NTERM]]);
            end
        end
    end

    // Stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p2_reg [NCYC][NTERM];
    logic signed [W-1:0]  x2_reg [NVERT];

    // Stage 3: cofactors
    logic                 v3_reg;
    logic signed [CF-1:0] c3_next [NCYC];
    logic signed [CF-1:0] c3_reg  [NCYC];
    logic signed [W-1:0]  x3_reg  [NVERT];

    always_comb begin
        for (int c = 0; c < NCYC; c++) begin
            c3_next[c] = CF'(p2_reg[c][0]) + CF'(p2_reg[c][1]) + CF'(p2_reg[c][2]);
        end
    end

    // Stage 4: determinant partial products, cofactor split in two slices
    logic                  v4_reg;
    logic signed [CF-1:0]  c4_reg   [NCOF];
    logic signed [PLW-1:0] plo4_reg [NVERT];
    logic signed [PW-1:0]  phi4_reg [NVERT];
    logic signed [PLW-1:0] plo4_next [NVERT];
    logic signed [PW-1:0]  phi4_next [NVERT];

    always_comb begin
        logic [LOW-1:0]        lo;
        logic signed [HIW-1:0] hi;
        for (int v = 0; v < NVERT; v++) begin
            lo = c3_reg[tij_pkg::DET_CYC[v]][LOW-1:0];
            hi = c3_reg[tij_pkg::DET_CYC[v]][CF-1:LOW];
            plo4_next[v] = PLW'(x3_reg[v]) * PLW'($signed({1'b0, lo}));
            phi4_next[v] = PW'(x3_reg[v]) * PW'(hi);
        end
    end

    // Stage 5: determinant
    logic                   v5_reg;
    logic signed [CF-1:0]   c5_reg [NCOF];
    logic signed [DETW-1:0] det5_next;
    logic signed [DETW-1:0] det5_reg;

    always_comb begin
        det5_next = '0;
        for (int v = 0; v < NVERT; v++) begin
            det5_next = det5_next + (DETW'(phi4_reg[v]) <<< LOW) + DETW'(plo4_reg[v]);
        end
    end

    // Divider pipeline, index 0 loaded by stage 6
    logic          dv_reg  [DIV_ST+1];
    logic          dgn_reg [DIV_ST+1];
    logic [MW-1:0] m_reg   [DIV_ST+1];
    logic [CW-1:0] rem_reg [DIV_ST+1][NCOF];
    logic [QW-1:0] q_reg   [DIV_ST+1][NCOF];
    logic          neg_reg [DIV_ST+1][NCOF];

    // Stage 6: magnitudes, rounding term and lane signs
    logic [DETW-1:0] dabs6;
    logic            dneg6;
    logic [CW-1:0]   n6_next   [NCOF];
    logic            neg6_next [NCOF];

    always_comb begin
        logic [CF-1:0] cabs;
        dneg6 = det5_reg[DETW-1];
        dabs6 = dneg6 ? DETW'(-det5_reg) : DETW'(det5_reg);
        for (int l = 0; l < NCOF; l++) begin
            cabs = c5_reg[l][CF-1] ? CF'(-c5_reg[l]) : CF'(c5_reg[l]);
            n6_next[l]   = (CW'(cabs) << (2 * FRAC_BITS + 1)) + CW'(dabs6);
            neg6_next[l] = c5_reg[l][CF-1] ^ dneg6;
        end
    end

    // Control: valid bits of stages 1..6
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end else if (advance) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
        end
    end

    // Payload of stages 1..6
    always_ff @(posedge aclk) begin
        if (advance) begin
            a1_reg <= a1_next;
            d1_reg <= d1_next;
            for (int v = 0; v < NVERT; v++) begin
                x1_reg[v] <= crd[tij_pkg::AXIS_X][v];
            end
            for (int c = 0; c < NCYC; c++) begin
                for (int t = 0; t < NTERM; t++) begin
                    p2_reg[c][t] <= PW'(a1_reg[c][t]) * PW'(d1_reg[c][t]);
                end
            end
            x2_reg   <= x1_reg;
            c3_reg   <= c3_next;
            x3_reg   <= x2_reg;
            for (int l = 0; l < NCOF; l++) begin
                c4_reg[l] <= c3_reg[l];
            end
            plo4_reg <= plo4_next;
            phi4_reg <= phi4_next;
            c5_reg   <= c4_reg;
            det5_reg <= det5_next;
            m_reg[0]   <= {dabs6, 1'b0};
            dgn_reg[0] <= (det5_reg == '0);
            rem_reg[0] <= n6_next;
            neg_reg[0] <= neg6_next;
            for (int l = 0; l < NCOF; l++) begin
                q_reg[0][l] <= '0;
            end
        end
    end

    // Restoring division: one quotient bit per stage, bits above the result width flag overflow
    for (genvar s = 0; s < DIV_ST; s++) begin : g_div
        localparam int SH = QW - 1 - s;
        logic [CW-1:0] rem_next [NCOF];
        logic [QW-1:0] q_next   [NCOF];

        always_comb begin
            logic [CW:0] trial;
            for (int l = 0; l < NCOF; l++) begin
                trial = {1'b0, rem_reg[s][l]} - {1'b0, (CW'(m_reg[s]) << SH)};
                rem_next[l] = trial[CW] ? rem_reg[s][l] : trial[CW-1:0];
                q_next[l]   = q_reg[s][l];
                q_next[l][SH] = !trial[CW];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[s+1] <= 1'b0;
            end else if (advance) begin
                dv_reg[s+1] <= dv_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                dgn_reg[s+1] <= dgn_reg[s];
                m_reg[s+1]   <= m_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                rem_reg[s+1] <= rem_next;
                q_reg[s+1]   <= q_next;
            end
        end
    end

    // Output: sign, saturation, degenerate override
    logic [W-1:0]        grad [NCOF];
    logic [NCOF-1:0]     lane_sat;
    logic [OUT_BITS-1:0] grad_packed;

    always_comb begin
        logic [QW-1:0] q;
        for (int l = 0; l < NCOF; l++) begin
            q = q_reg[DIV_ST][l];
            if (neg_reg[DIV_ST][l]) begin
                lane_sat[l] = (q[QW-1:W] != '0) || (q[W-1] && (q[W-2:0] != '0));
                grad[l]     = lane_sat[l] ? MIN_NEG : W'(-q[W-1:0]);
            end else begin
                lane_sat[l] = (q[QW-1:W-1] != '0);
                grad[l]     = lane_sat[l] ? MAX_POS : q[W-1:0];
            end
            if (dgn_reg[DIV_ST]) begin
                lane_sat[l] = 1'b0;
                grad[l]     = '0;
            end
            grad_packed[l*W +: W] = grad[l];
        end
    end

    logic              m_tvalid_reg;
    logic [OUT_TW-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= dv_reg[DIV_ST];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= OUT_TW'(grad_packed);
            m_tuser_reg <= {(|lane_sat), dgn_reg[DIV_ST]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
